// ===== rtl/hsvrgb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HSV to RGB converter package
// Item types, sector codes and the constants shared by the pipeline stages.
// ----------------------------------------------------------------------------
package hsvrgb_pkg;

  typedef struct packed {
    logic [7:0] hue;
    logic [7:0] saturation;
    logic [7:0] brightness;
  } hsv_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  typedef enum logic [2:0] {
    SECTOR_0 = 3'd0,
    SECTOR_1 = 3'd1,
    SECTOR_2 = 3'd2,
    SECTOR_3 = 3'd3,
    SECTOR_4 = 3'd4,
    SECTOR_5 = 3'd5
  } sector_e;

  // Side information that travels alongside the arithmetic stages.
  typedef struct packed {
    sector_e    sector;
    logic [7:0] brightness;
  } side_t;

  localparam int unsigned FULL_SCALE = 255;
  localparam int unsigned FULL_SQ    = FULL_SCALE * FULL_SCALE;
  // floor(2^32 / 65025); the estimate it gives is low by at most one.
  localparam int unsigned RECIP_SQ   = 66051;
  localparam int unsigned RECIP_SH   = 32;

endpackage

// ===== rtl/hsvrgb_product.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HSV to RGB product stages
// Two register stages forming the scaled products and the first quotient.
// ----------------------------------------------------------------------------
module hsvrgb_product (
  input  logic        clk_i,
  input  logic [7:0]  sat_i,
  input  logic [7:0]  val_i,
  input  logic [7:0]  frac_i,
  output logic [7:0]  p1_o,
  output logic [23:0] m2_o,
  output logic [23:0] m3_o
);
  import hsvrgb_pkg::*;

  logic [15:0] t1_d, t1_q;
  logic [15:0] a2_d, a2_q;
  logic [15:0] a3_d, a3_q;
  logic [7:0]  val_d, val_q;
  logic [15:0] n2, n3;
  logic [15:0] t1_sum;
  logic [7:0]  p1_d, p1_q;
  logic [23:0] m2_d, m2_q;
  logic [23:0] m3_d, m3_q;

  always_comb begin
    t1_d  = 16'(val_i) * 16'(8'(FULL_SCALE) - sat_i);
    a2_d  = 16'(sat_i) * 16'(frac_i);
    a3_d  = 16'(sat_i) * 16'(8'(FULL_SCALE) - frac_i);
    val_d = val_i;
  end

  always_ff @(posedge clk_i) begin
    t1_q  <= t1_d;
    a2_q  <= a2_d;
    a3_q  <= a3_d;
    val_q <= val_d;
  end

  always_comb begin
    t1_sum = t1_q + 16'd1 + {8'd0, t1_q[15:8]};
    p1_d   = t1_sum[15:8];
    n2     = 16'(FULL_SQ) - a2_q;
    n3     = 16'(FULL_SQ) - a3_q;
    m2_d   = 24'(val_q) * 24'(n2);
    m3_d   = 24'(val_q) * 24'(n3);
  end

  always_ff @(posedge clk_i) begin
    p1_q <= p1_d;
    m2_q <= m2_d;
    m3_q <= m3_d;
  end

  assign p1_o = p1_q;
  assign m2_o = m2_q;
  assign m3_o = m3_q;

endmodule

// ===== rtl/hsvrgb_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HSV to RGB quotient unit
// Floor division by 65025 through a registered reciprocal estimate and a
// single correction step.
// ----------------------------------------------------------------------------
module hsvrgb_div (
  input  logic        clk_i,
  input  logic [23:0] num_i,
  output logic [7:0]  quo_o
);
  import hsvrgb_pkg::*;

  logic [40:0] prod;
  logic [7:0]  est_d, est_q;
  logic [23:0] num_d, num_q;
  logic [23:0] back;
  logic [23:0] rem;

  always_comb begin
    prod  = 41'(num_i) * 41'(RECIP_SQ);
    est_d = prod[RECIP_SH+7:RECIP_SH];
    num_d = num_i;
  end

  always_ff @(posedge clk_i) begin
    est_q <= est_d;
    num_q <= num_d;
  end

  always_comb begin
    back  = 24'(est_q) * 24'(FULL_SQ);
    rem   = num_q - back;
    quo_o = (rem >= 24'(FULL_SQ)) ? est_q + 8'd1 : est_q;
  end

endmodule

// ===== rtl/hsv_to_rgb_converter_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HSV to RGB converter core
// Converts one 8-bit hue, saturation and brightness item into 8-bit red,
// green and blue with exact floor rounding.
// ----------------------------------------------------------------------------
// The core takes an item in every clock cycle and busy_o stays low. Each
// result appears on rgb_o with done_o high for exactly one cycle, after the
// five register stages of sector split, two product stages, the reciprocal
// divider and the output select. Results leave in the order their items
// arrived.
module hsv_to_rgb_converter_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  hsvrgb_pkg::hsv_t   hsv_i,
  output logic               done_o,
  output hsvrgb_pkg::rgb_t   rgb_o
);
  import hsvrgb_pkg::*;

  logic [10:0] scaled;
  sector_e     sector_d;
  logic [7:0]  frac_d;
  logic        accept;

  logic [4:0]  valid_q;
  logic [4:0]  valid_d;

  sector_e     sector_q;
  logic [7:0]  frac_q;
  logic [7:0]  sat_q;
  logic [7:0]  val_q;

  side_t       side_d;
  side_t       side2_q, side3_q, side4_q;
  logic [7:0]  p1_s3, p1_q;
  logic [23:0] m2_s3, m3_s3;
  logic [7:0]  p2, p3;

  rgb_t        rgb_d, rgb_q;

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  always_comb begin
    scaled = {1'b0, hsv_i.hue, 2'b00} + {2'b00, hsv_i.hue, 1'b0};
    priority if (scaled >= 11'(6 * FULL_SCALE)) begin
      sector_d = SECTOR_5;
      frac_d   = 8'd0;
    end else if (scaled >= 11'(5 * FULL_SCALE)) begin
      sector_d = SECTOR_5;
      frac_d   = 8'(scaled - 11'(5 * FULL_SCALE));
    end else if (scaled >= 11'(4 * FULL_SCALE)) begin
      sector_d = SECTOR_4;
      frac_d   = 8'(scaled - 11'(4 * FULL_SCALE));
    end else if (scaled >= 11'(3 * FULL_SCALE)) begin
      sector_d = SECTOR_3;
      frac_d   = 8'(scaled - 11'(3 * FULL_SCALE));
    end else if (scaled >= 11'(2 * FULL_SCALE)) begin
      sector_d = SECTOR_2;
      frac_d   = 8'(scaled - 11'(2 * FULL_SCALE));
    end else if (scaled >= 11'(FULL_SCALE)) begin
      sector_d = SECTOR_1;
      frac_d   = 8'(scaled - 11'(FULL_SCALE));
    end else begin
      sector_d = SECTOR_0;
      frac_d   = scaled[7:0];
    end
  end

  always_ff @(posedge clk_i) begin
    sector_q <= sector_d;
    frac_q   <= frac_d;
    sat_q    <= hsv_i.saturation;
    val_q    <= hsv_i.brightness;
  end

  assign valid_d = {valid_q[3:0], accept};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign side_d = '{sector: sector_q, brightness: val_q};

  always_ff @(posedge clk_i) begin
    side2_q <= side_d;
    side3_q <= side2_q;
    side4_q <= side3_q;
    p1_q    <= p1_s3;
  end

  hsvrgb_product u_product (
    .clk_i  (clk_i),
    .sat_i  (sat_q),
    .val_i  (val_q),
    .frac_i (frac_q),
    .p1_o   (p1_s3),
    .m2_o   (m2_s3),
    .m3_o   (m3_s3)
  );

  hsvrgb_div u_div_p2 (
    .clk_i (clk_i),
    .num_i (m2_s3),
    .quo_o (p2)
  );

  hsvrgb_div u_div_p3 (
    .clk_i (clk_i),
    .num_i (m3_s3),
    .quo_o (p3)
  );

  always_comb begin
    unique case (side4_q.sector)
      SECTOR_0: rgb_d = '{red: side4_q.brightness, green: p3, blue: p1_q};
      SECTOR_1: rgb_d = '{red: p2, green: side4_q.brightness, blue: p1_q};
      SECTOR_2: rgb_d = '{red: p1_q, green: side4_q.brightness, blue: p3};
      SECTOR_3: rgb_d = '{red: p1_q, green: p2, blue: side4_q.brightness};
      SECTOR_4: rgb_d = '{red: p3, green: p1_q, blue: side4_q.brightness};
      SECTOR_5: rgb_d = '{red: side4_q.brightness, green: p1_q, blue: p2};
      default:  rgb_d = '{red: side4_q.brightness, green: p1_q, blue: p2};
    endcase
  end

  always_ff @(posedge clk_i) begin
    rgb_q <= rgb_d;
  end

  assign done_o = valid_q[4];
  assign rgb_o  = rgb_q;

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HSV to RGB converter core testbench
// Sends a table of directed items and then weighted random items into the
// core with random start gaps, predicts each red, green and blue result from
// exact floor math or a pinned table row and checks every result in order.
// ----------------------------------------------------------------------------
module tb_top;
  import hsvrgb_pkg::*;

  localparam int unsigned DIRECTED_ROWS  = 22;
  localparam int unsigned RANDOM_ITEMS   = 850;
  localparam int unsigned MAX_GAP        = 18;
  localparam int unsigned LATENCY        = 5;
  localparam int unsigned WATCHDOG_LIMIT = 200;

  typedef struct packed {
    logic pinned;
    hsv_t stim;
    rgb_t want;
  } dir_row_t;

  localparam dir_row_t DIRECTED [DIRECTED_ROWS] = '{
    '{1'b1, '{8'd0,   8'd0,   8'd0},   '{8'd0,   8'd0,   8'd0}},
    '{1'b1, '{8'd255, 8'd255, 8'd255}, '{8'd255, 8'd0,   8'd255}},
    '{1'b1, '{8'd0,   8'd255, 8'd255}, '{8'd255, 8'd0,   8'd0}},
    '{1'b1, '{8'd0,   8'd0,   8'd255}, '{8'd255, 8'd255, 8'd255}},
    '{1'b1, '{8'd255, 8'd0,   8'd128}, '{8'd128, 8'd128, 8'd128}},
    '{1'b1, '{8'd85,  8'd255, 8'd255}, '{8'd0,   8'd255, 8'd0}},
    '{1'b1, '{8'd170, 8'd255, 8'd255}, '{8'd0,   8'd0,   8'd255}},
    '{1'b1, '{8'd200, 8'd255, 8'd0},   '{8'd0,   8'd0,   8'd0}},
    '{1'b0, '{8'd42,  8'd255, 8'd255}, '0},
    '{1'b0, '{8'd43,  8'd200, 8'd240}, '0},
    '{1'b0, '{8'd84,  8'd128, 8'd200}, '0},
    '{1'b0, '{8'd100, 8'd1,   8'd255}, '0},
    '{1'b0, '{8'd128, 8'd255, 8'd1},   '0},
    '{1'b0, '{8'd150, 8'd170, 8'd85},  '0},
    '{1'b0, '{8'd212, 8'd254, 8'd254}, '0},
    '{1'b0, '{8'd213, 8'd255, 8'd255}, '0},
    '{1'b0, '{8'd254, 8'd255, 8'd255}, '0},
    '{1'b0, '{8'd1,   8'd255, 8'd255}, '0},
    '{1'b0, '{8'd255, 8'd1,   8'd1},   '0},
    '{1'b0, '{8'd127, 8'd170, 8'd85},  '0},
    '{1'b0, '{8'd86,  8'd254, 8'd254}, '0},
    '{1'b0, '{8'd171, 8'd127, 8'd255}, '0}
  };

  logic clk_i = 1'b0;
  logic rst_ni;
  logic start_i;
  logic busy_o;
  hsv_t hsv_i;
  logic done_o;
  rgb_t rgb_o;

  logic        pinned_en;
  rgb_t        pinned_rgb;
  rgb_t        pending_rgb [$];
  int unsigned errors_seen = 0;
  int unsigned quiet_cycles = 0;

  hsv_to_rgb_converter_core dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .busy_o  (busy_o),
    .hsv_i   (hsv_i),
    .done_o  (done_o),
    .rgb_o   (rgb_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  function automatic rgb_t hsv_to_rgb(hsv_t px);
    int unsigned h, s, v, scaled, frac, p1, p2, p3;
    sector_e     sec;
    rgb_t        c;
    h = px.hue;
    s = px.saturation;
    v = px.brightness;
    if (s == 0) begin
      c = '{8'(v), 8'(v), 8'(v)};
    end else begin
      scaled = h * 6;
      frac   = scaled % FULL_SCALE;
      sec    = (scaled / FULL_SCALE > 5) ? SECTOR_5 : sector_e'(scaled / FULL_SCALE);
      p1 = v * (FULL_SCALE - s) / FULL_SCALE;
      p2 = v * (FULL_SQ - s * frac) / FULL_SQ;
      p3 = v * (FULL_SQ - s * (FULL_SCALE - frac)) / FULL_SQ;
      case (sec)
        SECTOR_0: c = '{8'(v),  8'(p3), 8'(p1)};
        SECTOR_1: c = '{8'(p2), 8'(v),  8'(p1)};
        SECTOR_2: c = '{8'(p1), 8'(v),  8'(p3)};
        SECTOR_3: c = '{8'(p1), 8'(p2), 8'(v)};
        SECTOR_4: c = '{8'(p3), 8'(p1), 8'(v)};
        default:  c = '{8'(v),  8'(p1), 8'(p2)};
      endcase
    end
    return c;
  endfunction

  function automatic hsv_t random_hsv();
    hsv_t        px;
    int unsigned pick;
    px.hue        = 8'($urandom);
    px.saturation = 8'($urandom);
    px.brightness = 8'($urandom);
    case ($urandom_range(0, 9))
      0: px.saturation = 8'd0;
      1: px.saturation = 8'd255;
      2: px.brightness = 8'd255;
      3: px.brightness = 8'($urandom_range(0, 1));
      4: begin
        pick   = $urandom_range(0, 6);
        px.hue = 8'(pick * 85 / 2 + $urandom_range(0, 2)) - 8'd1;
        if (pick == 6 && $urandom_range(0, 1) == 0) px.hue = 8'd255;
      end
      default: ;
    endcase
    return px;
  endfunction

  task automatic send_hsv(input hsv_t px, input logic pin, input rgb_t want,
                          input int unsigned gap);
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start_i    <= 1'b1;
    hsv_i      <= px;
    pinned_en  <= pin;
    pinned_rgb <= want;
    do @(posedge clk_i); while (busy_o);
    @(negedge clk_i);
  endtask

  task automatic drain_results();
    start_i <= 1'b0;
    while (pending_rgb.size() != 0) @(negedge clk_i);
  endtask

  always @(posedge clk_i) begin
    rgb_t want;
    if (done_o) begin
      if (pending_rgb.size() == 0) begin
        $error("unexpected result red=%0d green=%0d blue=%0d",
               rgb_o.red, rgb_o.green, rgb_o.blue);
        errors_seen++;
      end else begin
        want = pending_rgb.pop_front();
        if (rgb_o.red !== want.red) begin
          $error("red: expected %0d, got %0d", want.red, rgb_o.red);
          errors_seen++;
        end
        if (rgb_o.green !== want.green) begin
          $error("green: expected %0d, got %0d", want.green, rgb_o.green);
          errors_seen++;
        end
        if (rgb_o.blue !== want.blue) begin
          $error("blue: expected %0d, got %0d", want.blue, rgb_o.blue);
          errors_seen++;
        end
      end
    end
    if (rst_ni && start_i && !busy_o) begin
      pending_rgb.push_back(pinned_en ? pinned_rgb : hsv_to_rgb(hsv_i));
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start_i && !busy_o) || done_o) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("tb_top: errors");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin : stimulus
    int unsigned idx;
    int unsigned gap;
    logic        idle_on;
    rst_ni     = 1'b0;
    start_i    = 1'b0;
    hsv_i      = '0;
    pinned_en  = 1'b0;
    pinned_rgb = '0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    for (idx = 0; idx < DIRECTED_ROWS; idx++) begin
      gap = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(0, MAX_GAP);
      send_hsv(DIRECTED[idx].stim, DIRECTED[idx].pinned, DIRECTED[idx].want, gap);
    end
    drain_results();

    idle_on = 1'b0;
    for (idx = 0; idx < RANDOM_ITEMS; idx++) begin
      if (idx % 60 == 0) idle_on = ($urandom_range(0, 2) != 0);
      if (idx == RANDOM_ITEMS / 2) drain_results();
      gap = idle_on ? $urandom_range(0, MAX_GAP) : 0;
      send_hsv(random_hsv(), 1'b0, '0, gap);
    end
    drain_results();
    repeat (2 * LATENCY) @(posedge clk_i);

    if (errors_seen == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
